// ===== rtl/brf_pkg.sv =====
// Shared codes and types for the block ring FIFO.
// Depends on nothing; every other file of the block imports it.
package brf_pkg;

	// Request codes carried on req_type.
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_PEEK  = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	// Operations of the shared pointer and count unit.
	typedef logic [1:0] brf_op_t;
	localparam brf_op_t OP_HOLD = 2'd0;
	localparam brf_op_t OP_INC  = 2'd1;
	localparam brf_op_t OP_DEC  = 2'd2;

	// Result status codes.
	localparam logic ST_OK     = 1'b0;
	localparam logic ST_REJECT = 1'b1;

	// Field widths fixed by the interface.
	localparam int LEN_W  = 7;
	localparam int CNT_W  = 7;
	localparam int CAP_W  = 7;
	localparam int REQ_W  = 2;
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	typedef logic [LEN_W-1:0] brf_len_t;
	typedef logic [CNT_W-1:0] brf_cnt_t;
	typedef logic [CAP_W-1:0] brf_cap_t;
	typedef logic [REQ_W-1:0] brf_req_t;

	// Longest read or peek burst that one request may ask for.
	localparam brf_len_t MAX_BURST = 7'd64;

	// Register indexes on the configuration port.
	localparam logic REG_CAPACITY = 1'b0;

endpackage

// ===== rtl/brf_unit.sv =====
// Shared pointer and count unit of the block ring FIFO: wrapping pointer
// advance, count step and free-space figure. Depends on brf_pkg.
module brf_unit #(
	parameter int DEPTH = 64
) (
	input  logic [$clog2(DEPTH)-1:0]   ptr_in,
	input  logic [$clog2(DEPTH+1)-1:0] cnt_in,
	input  logic [$clog2(DEPTH+1)-1:0] cap,
	input  brf_pkg::brf_op_t           op,
	output logic [$clog2(DEPTH)-1:0]   ptr_next,
	output logic [$clog2(DEPTH+1)-1:0] cnt_next,
	output logic [$clog2(DEPTH+1)-1:0] free_next
);
	import brf_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	// The pointer wraps at the built depth, which need not be a power of two.
	assign ptr_next = (ptr_in == PW'(DEPTH - 1)) ? '0 : ptr_in + PW'(1);

	always_comb begin
		case (op)
			OP_INC:  cnt_next = cnt_in + CW'(1);
			OP_DEC:  cnt_next = cnt_in - CW'(1);
			default: cnt_next = cnt_in;
		endcase
	end

	// Free space never goes below zero when the capacity is lowered under the fill.
	assign free_next = (cnt_next >= cap) ? '0 : cap - cnt_next;

endmodule

// ===== rtl/brf_mem.sv =====
// Word store of the block ring FIFO: one write port, one registered read port.
// Depends on brf_pkg only by convention; no reset, contents undefined until written.
module brf_mem #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WORD_BITS-1:0]     wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WORD_BITS-1:0]     rd_data
);
	import brf_pkg::*;

	logic [WORD_BITS-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== rtl/brf_seq.sv =====
// Sequencer of the block ring FIFO: request decode, write-block bookkeeping,
// read and peek bursts and the output register. Depends on brf_pkg and brf_unit.
module brf_seq #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  brf_pkg::brf_cap_t        capacity,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  brf_pkg::brf_req_t        req_type,
	input  logic [WORD_BITS-1:0]     elem_value,
	input  brf_pkg::brf_len_t        block_length,
	input  logic                     last_in,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [WORD_BITS-1:0]     out_value,
	output logic                     status,
	output brf_pkg::brf_cnt_t        done_count,
	output brf_pkg::brf_cnt_t        used_count,
	output brf_pkg::brf_cnt_t        free_count,
	output logic                     last_out,
	output logic                     wr_en,
	output logic [$clog2(DEPTH)-1:0] wr_addr,
	output logic [WORD_BITS-1:0]     wr_data,
	output logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic [WORD_BITS-1:0]     rd_data
);
	import brf_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);
	// Wide enough for a count plus a block length without overflow.
	localparam int SW = ((CW > LEN_W) ? CW : LEN_W) + 1;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic          state_q;
	logic [PW-1:0] rd_ptr_q, wr_ptr_q, cursor_q;
	logic [CW-1:0] count_q;
	logic          wb_open_q, wb_rej_q;
	brf_len_t      wb_done_q, wb_len_q;
	brf_len_t      remain_q, blen_q;
	logic          peek_q;
	logic          out_valid_q;

	logic [CW-1:0] eff_cap;
	logic          out_free, in_fire, is_write, is_burst_req;
	brf_len_t      cur_len, cur_done, done_new;
	logic          rej_new, cur_rej, rd_bad, do_write, start_burst, burst_fire;
	logic          load_out, burst_last;
	logic [PW-1:0] u_ptr_in, u_ptr_next;
	logic [CW-1:0] u_cnt_next, u_free;
	brf_op_t       u_op;

	logic [WORD_BITS-1:0] nx_value;
	logic                 nx_status, nx_last;
	brf_len_t             nx_done;
	logic [CW-1:0]        nx_used, nx_free;

	// A capacity of zero acts as one, and one above the built depth as the depth.
	always_comb begin
		if (capacity == '0) begin
			eff_cap = CW'(1);
		end else if (SW'(capacity) > SW'(DEPTH)) begin
			eff_cap = CW'(DEPTH);
		end else begin
			eff_cap = CW'(capacity);
		end
	end

	assign out_free     = !out_valid_q || out_ready;
	assign in_ready     = (state_q == S_IDLE) && out_free;
	assign in_fire      = in_valid && in_ready;
	assign is_write     = (req_type == REQ_WRITE);
	assign is_burst_req = (req_type == REQ_READ) || (req_type == REQ_PEEK);

	// The first element of a write block latches its length and admission.
	assign rej_new  = (block_length == '0) ||
			(SW'(count_q) + SW'(block_length) > SW'(eff_cap));
	assign cur_len  = wb_open_q ? wb_len_q : block_length;
	assign cur_done = wb_open_q ? wb_done_q : '0;
	assign cur_rej  = wb_open_q ? wb_rej_q : rej_new;
	assign do_write = in_fire && is_write && !cur_rej && (cur_done < cur_len) &&
			(count_q < CW'(DEPTH));
	assign done_new = cur_done + LEN_W'(do_write);

	assign rd_bad      = (block_length == '0) || (block_length > MAX_BURST) ||
			(SW'(block_length) > SW'(count_q));
	assign start_burst = in_fire && is_burst_req && !rd_bad;
	assign burst_fire  = (state_q == S_READ) && out_free;
	assign burst_last  = (remain_q == LEN_W'(1));

	// The shared unit steps the write pointer on a store, or the burst cursor.
	always_comb begin
		if (state_q == S_READ) begin
			u_ptr_in = cursor_q;
			u_op     = peek_q ? OP_HOLD : OP_DEC;
		end else begin
			u_ptr_in = wr_ptr_q;
			u_op     = do_write ? OP_INC : OP_HOLD;
		end
	end

	brf_unit #(
		.DEPTH(DEPTH)
	) u_unit (
		.ptr_in   (u_ptr_in),
		.cnt_in   (count_q),
		.cap      (eff_cap),
		.op       (u_op),
		.ptr_next (u_ptr_next),
		.cnt_next (u_cnt_next),
		.free_next(u_free)
	);

	// Reading one ahead keeps the registered store output in step with the cursor.
	always_comb begin
		if (state_q == S_READ) begin
			rd_addr = burst_fire ? u_ptr_next : cursor_q;
		end else begin
			rd_addr = rd_ptr_q;
		end
	end

	assign wr_en   = do_write;
	assign wr_addr = wr_ptr_q;
	assign wr_data = elem_value;

	always_comb begin
		load_out  = 1'b0;
		nx_value  = '0;
		nx_status = ST_OK;
		nx_done   = '0;
		nx_used   = u_cnt_next;
		nx_free   = u_free;
		nx_last   = 1'b1;
		if (state_q == S_READ) begin
			load_out = burst_fire;
			nx_value = rd_data;
			nx_done  = burst_last ? blen_q : '0;
			nx_last  = burst_last;
		end else if (in_fire) begin
			case (req_type)
				REQ_WRITE: begin
					load_out  = last_in;
					nx_status = cur_rej ? ST_REJECT : ST_OK;
					nx_done   = cur_rej ? '0 : done_new;
				end
				REQ_CLEAR: begin
					load_out = 1'b1;
					nx_used  = '0;
					nx_free  = eff_cap;
				end
				default: begin
					load_out  = rd_bad;
					nx_status = ST_REJECT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			cursor_q    <= '0;
			count_q     <= '0;
			wb_open_q   <= 1'b0;
			wb_rej_q    <= 1'b0;
			wb_done_q   <= '0;
			wb_len_q    <= '0;
			remain_q    <= '0;
			blen_q      <= '0;
			peek_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (in_fire) begin
				if (is_write && !last_in) begin
					wb_open_q <= 1'b1;
					wb_rej_q  <= cur_rej;
					wb_done_q <= done_new;
					wb_len_q  <= cur_len;
				end else begin
					wb_open_q <= 1'b0;
					wb_rej_q  <= 1'b0;
					wb_done_q <= '0;
				end
				if (req_type == REQ_CLEAR) begin
					rd_ptr_q <= '0;
					wr_ptr_q <= '0;
					count_q  <= '0;
				end
			end

			if (do_write) begin
				wr_ptr_q <= u_ptr_next;
				count_q  <= u_cnt_next;
			end

			if (start_burst) begin
				state_q  <= S_READ;
				cursor_q <= rd_ptr_q;
				remain_q <= block_length;
				blen_q   <= block_length;
				peek_q   <= (req_type == REQ_PEEK);
			end

			if (burst_fire) begin
				cursor_q <= u_ptr_next;
				remain_q <= remain_q - LEN_W'(1);
				if (!peek_q) begin
					rd_ptr_q <= u_ptr_next;
					count_q  <= u_cnt_next;
				end
				if (burst_last) begin
					state_q <= S_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_value  <= nx_value;
			status     <= nx_status;
			done_count <= nx_done;
			used_count <= CNT_W'(nx_used);
			free_count <= CNT_W'(nx_free);
			last_out   <= nx_last;
		end
	end

	assign out_valid = out_valid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("stored count exceeds the built depth");

	a_burst_remain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (remain_q != '0))
		else $error("burst running with nothing left to emit");

	a_burst_start: assert property (@(posedge clk) disable iff (!arst_n)
		start_burst |-> (SW'(block_length) <= SW'(count_q)))
		else $error("burst started with too few words stored");

	a_no_write_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> !wr_en)
		else $error("store written during a burst");

	a_peek_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ && peek_q && burst_fire) |=> (count_q == $past(count_q)))
		else $error("peek burst changed the stored count");

endmodule

// ===== rtl/block_ring_fifo.sv =====
// Top level of the block ring FIFO: configuration register, word store and sequencer.
// Depends on brf_pkg, brf_mem and brf_seq.
//
// The block is a ring FIFO of WORD_BITS-bit words with all-or-nothing block
// transfers. A write block arrives as one beat per element; only its final
// beat (last_in high) gives a result beat, carrying the status and the number
// of words stored. A read or peek block of N words is accepted and then gives
// N words of output, one word per cycle while the output register is free,
// from the single registered read port of the store; the block takes no new
// input beat until the last word of the burst has entered the output
// register. A clear, or a read or peek that cannot be served, gives one
// result beat. Every result beat reports the used and free counts after it.
// Any input beat waits while a result beat is held in the output register.
// The capacity register (byte address 0) may be set to any value up to the
// built depth; zero acts as one and a value above the depth acts as the
// depth. If the capacity is lowered below the stored count, the words are
// kept and write blocks are rejected until enough have been read. The store
// needs no clearing pass after reset, so the block is ready in the first
// cycle.
module block_ring_fifo #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Configuration port.
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [brf_pkg::APB_AW-1:0] paddr,
	input  logic [brf_pkg::APB_DW-1:0] pwdata,
	output logic [brf_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	// Request channel.
	input  logic                       in_valid,
	output logic                       in_ready,
	input  brf_pkg::brf_req_t          req_type,
	input  logic [WORD_BITS-1:0]       elem_value,
	input  brf_pkg::brf_len_t          block_length,
	input  logic                       last_in,
	// Result channel.
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [WORD_BITS-1:0]       out_value,
	output logic                       status,
	output brf_pkg::brf_cnt_t          done_count,
	output brf_pkg::brf_cnt_t          used_count,
	output brf_pkg::brf_cnt_t          free_count,
	output logic                       last_out
);
	import brf_pkg::*;

	localparam int PW = $clog2(DEPTH);

	brf_cap_t             cap_q;
	logic                 reg_idx;
	logic                 mem_wr_en;
	logic [PW-1:0]        mem_wr_addr, mem_rd_addr;
	logic [WORD_BITS-1:0] mem_wr_data, mem_rd_data;

	// Registers sit on 32-bit words, so the word index is the address above bit 1.
	assign reg_idx = paddr[2];
	assign pready  = 1'b1;

	// The capacity is written in the access phase of a write beat; writes to
	// other addresses are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 7'd64;
		end else if (psel && penable && pwrite && (reg_idx == REG_CAPACITY)) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = (reg_idx == REG_CAPACITY) ? APB_DW'(cap_q) : '0;

	brf_mem #(
		.DEPTH    (DEPTH),
		.WORD_BITS(WORD_BITS)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	brf_seq #(
		.DEPTH    (DEPTH),
		.WORD_BITS(WORD_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.capacity    (cap_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.elem_value  (elem_value),
		.block_length(block_length),
		.last_in     (last_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_value   (out_value),
		.status      (status),
		.done_count  (done_count),
		.used_count  (used_count),
		.free_count  (free_count),
		.last_out    (last_out),
		.wr_en       (mem_wr_en),
		.wr_addr     (mem_wr_addr),
		.wr_data     (mem_wr_data),
		.rd_addr     (mem_rd_addr),
		.rd_data     (mem_rd_data)
	);

endmodule
